### rtl/pal_pkg.sv
// Shared types, codes and helpers for the positional array list.
package pal_pkg;

    // Request action codes
    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_INS_END   = 3'd1;
    localparam logic [2:0] ACT_INS_POS   = 3'd2;
    localparam logic [2:0] ACT_REM_FRONT = 3'd3;
    localparam logic [2:0] ACT_REM_END   = 3'd4;
    localparam logic [2:0] ACT_REM_POS   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Fan-in of one level of the removed-word reduction tree
    localparam int TREE_RADIX = 8;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic advance;  // pipeline moves this cycle
        logic ins;      // committed insert at the target index
        logic rem;      // committed remove at the target index
    } pal_op_t;

    // Number of registered levels needed to reduce n leaves to one
    function automatic int tree_levels(input int n);
        int lvl;
        int span;
        lvl  = 1;
        span = TREE_RADIX;
        while (span < n) begin
            span = span * TREE_RADIX;
            lvl  = lvl + 1;
        end
        return lvl;
    endfunction

endpackage

### rtl/pal_req_if.sv
// Request channel: valid/ready handshake with the list request payload.
interface pal_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [6:0] position;
    logic [31:0] item_data;

    modport source (output valid, output action, output position, output item_data,
                    input ready);
    modport sink   (input valid, input action, input position, input item_data,
                    output ready);
endinterface

### rtl/pal_rsp_if.sv
// Response channel: valid/ready handshake with the list result payload.
interface pal_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] removed_data;
    logic [1:0]  status;
    logic [6:0]  entry_count;

    modport source (output valid, output removed_data, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input removed_data, input status,
                    input entry_count, output ready);
endinterface

### rtl/positional_array_list.sv
// Positional array list top level: request decode, cell chain, result pipeline.
// A removed word passes through the cell capture register and then each registered level
// of the radix-8 OR tree on its way from the request beat to the result register.
// Throughput: one request per cycle while results are taken; the list state
// updates in the beat's own cycle, so a following request sees it at once.
// Reset clears the entry count and the result valid flags; entries stay undefined.
module positional_array_list #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input logic    clk,
    input logic    rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);
    import pal_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int CW     = (IDX_W > 7) ? IDX_W : 7;
    localparam int LEVELS = tree_levels(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      cnt_next;
    logic [CW-1:0]         cnt_wide;
    logic [CW-1:0]         pos_wide;
    logic                  advance;
    logic                  fire;
    logic                  is_ins;
    logic                  is_rem;
    logic [1:0]            status;
    logic [CW-1:0]         tgt_wide;
    logic [IDX_W-1:0]      target;
    pal_op_t               op;
    logic [DATA_WIDTH-1:0] new_word;
    logic [DATA_WIDTH-1:0] cell_word  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_taken [CAPACITY];
    logic [DATA_WIDTH-1:0] root;

    logic                  vld_reg    [LEVELS+1];
    logic [1:0]            st_reg     [LEVELS+1];
    logic [6:0]            ec_reg     [LEVELS+1];

    assign cnt_wide = CW'(cnt_reg);
    assign pos_wide = CW'(req.position);
    assign new_word = DATA_WIDTH'(req.item_data);

    // Stall everything while the result register holds an untaken beat
    assign advance   = !vld_reg[LEVELS] || rsp.ready;
    assign req.ready = advance;
    assign fire      = req.valid && advance;

    // Decode the action into a target index and a status
    always_comb
    begin
        is_ins   = 1'b0;
        is_rem   = 1'b0;
        status   = ST_OK;
        tgt_wide = '0;
        unique case (req.action) inside
            ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS:
            begin
                if (req.action == ACT_INS_FRONT) begin
                    tgt_wide = '0;
                end else if (req.action == ACT_INS_END) begin
                    tgt_wide = cnt_wide;
                end else begin
                    tgt_wide = pos_wide;
                end
                if (cnt_wide >= CAP_C) begin
                    status = ST_FULL;
                end else if (req.action == ACT_INS_POS && pos_wide > cnt_wide) begin
                    status = ST_RANGE;
                end else begin
                    is_ins = 1'b1;
                end
            end
            ACT_REM_FRONT, ACT_REM_END, ACT_REM_POS:
            begin
                if (req.action == ACT_REM_FRONT) begin
                    tgt_wide = '0;
                end else if (req.action == ACT_REM_END) begin
                    tgt_wide = cnt_wide - CW'(1);
                end else begin
                    tgt_wide = pos_wide;
                end
                if (cnt_wide == '0) begin
                    status = ST_EMPTY;
                end else if (req.action == ACT_REM_POS && pos_wide >= cnt_wide) begin
                    status = ST_RANGE;
                end else begin
                    is_rem = 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign target     = tgt_wide[IDX_W-1:0];
    assign op.advance = advance;
    assign op.ins     = fire && is_ins;
    assign op.rem     = fire && is_rem;

    // Count follows committed inserts and removals
    always_comb
    begin
        cnt_next = cnt_reg;
        if (op.ins) begin
            cnt_next = cnt_reg + IDX_W'(1);
        end else if (op.rem) begin
            cnt_next = cnt_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Row of cells, each wired to its two neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_w;
        logic [DATA_WIDTH-1:0] next_w;
        if (i == 0) begin : g_first
            assign prev_w = '0;
        end else begin : g_mid_lo
            assign prev_w = cell_word[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_w = '0;
        end else begin : g_mid_hi
            assign next_w = cell_word[i+1];
        end
        pal_cell #(
            .INDEX      (i),
            .IDX_W      (IDX_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .target    (target),
            .new_word  (new_word),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[i]),
            .taken     (cell_taken[i])
        );
    end

    // Gather the removed word
    pal_or_tree #(
        .N (CAPACITY),
        .W (DATA_WIDTH)
    ) u_tree (
        .clk     (clk),
        .advance (advance),
        .leaf    (cell_taken),
        .root    (root)
    );

    // Carry status and count alongside the tree
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s <= LEVELS; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (advance) begin
            vld_reg[0] <= fire;
            for (int s = 1; s <= LEVELS; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            st_reg[0] <= status;
            ec_reg[0] <= 7'(cnt_next);
            for (int s = 1; s <= LEVELS; s++) begin
                st_reg[s] <= st_reg[s-1];
                ec_reg[s] <= ec_reg[s-1];
            end
        end
    end

    assign rsp.valid        = vld_reg[LEVELS];
    assign rsp.status       = st_reg[LEVELS];
    assign rsp.entry_count  = ec_reg[LEVELS];
    assign rsp.removed_data = 32'(root);

    // Count never passes capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= IDX_W'(CAPACITY))
        else $error("entry count above capacity");

    // A failed request leaves the count alone
    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status != ST_OK) |=> cnt_reg == $past(cnt_reg))
        else $error("failed request changed the count");

    // A committed insert grows the count by one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        op.ins |=> cnt_reg == $past(cnt_reg) + IDX_W'(1))
        else $error("insert did not grow the count");

    // A committed remove shrinks the count by one
    a_rem_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        op.rem |=> cnt_reg == $past(cnt_reg) - IDX_W'(1))
        else $error("remove did not shrink the count");

    // A failed result carries no removed word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> rsp.removed_data == '0)
        else $error("failed result carries a removed word");

endmodule

### rtl/pal_cell.sv
// One list slot: holds a word, shifts with its neighbors, offers it on removal.
module pal_cell #(
    parameter int INDEX      = 0,
    parameter int IDX_W      = 7,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  pal_pkg::pal_op_t      op,
    input  logic [IDX_W-1:0]      target,
    input  logic [DATA_WIDTH-1:0] new_word,
    input  logic [DATA_WIDTH-1:0] prev_word,
    input  logic [DATA_WIDTH-1:0] next_word,
    output logic [DATA_WIDTH-1:0] word,
    output logic [DATA_WIDTH-1:0] taken
);
    import pal_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic [DATA_WIDTH-1:0] taken_reg;
    logic [DATA_WIDTH-1:0] taken_next;
    logic                  at_target;
    logic                  above_target;

    assign at_target    = (MY_IDX == target);
    assign above_target = (MY_IDX > target);

    // Take the new word, shift up from below, or shift down from above
    always_comb
    begin
        word_next = word_reg;
        if (op.ins) begin
            if (at_target) begin
                word_next = new_word;
            end else if (above_target) begin
                word_next = prev_word;
            end
        end else if (op.rem) begin
            if (at_target || above_target) begin
                word_next = next_word;
            end
        end
    end

    // Offer the outgoing word to the reduction tree, zero elsewhere
    assign taken_next = (op.rem && at_target) ? word_reg : '0;

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (op.advance) begin
            taken_reg <= taken_next;
        end
    end

    assign word  = word_reg;
    assign taken = taken_reg;

endmodule

### rtl/pal_or_tree.sv
// Registered radix-8 OR tree that gathers the one removed word from all cells.
module pal_or_tree #(
    parameter int N = 64,
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         advance,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] root
);
    import pal_pkg::*;

    localparam int LEVELS = tree_levels(N);
    localparam int PAD    = TREE_RADIX ** LEVELS;

    logic [W-1:0] leaf_pad [PAD];
    logic [W-1:0] lvl_reg  [1:LEVELS][PAD];

    // Pad the leaf row up to a full tree with zeros
    for (genvar j = 0; j < PAD; j++) begin : g_pad
        if (j < N) begin : g_real
            assign leaf_pad[j] = leaf[j];
        end else begin : g_zero
            assign leaf_pad[j] = '0;
        end
    end

    // Reduce eight children per node, one register level per tree level
    for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
        localparam int NODES = PAD / (TREE_RADIX ** (k + 1));
        for (genvar j = 0; j < NODES; j++) begin : g_node
            logic [W-1:0] acc;
            if (k == 0) begin : g_leaf
                always_comb
                begin
                    acc = '0;
                    for (int c = 0; c < TREE_RADIX; c++) begin
                        acc = acc | leaf_pad[j*TREE_RADIX + c];
                    end
                end
            end else begin : g_inner
                always_comb
                begin
                    acc = '0;
                    for (int c = 0; c < TREE_RADIX; c++) begin
                        acc = acc | lvl_reg[k][j*TREE_RADIX + c];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (advance) begin
                    lvl_reg[k+1][j] <= acc;
                end
            end
        end
    end

    assign root = lvl_reg[LEVELS][0];

endmodule

### verif/pal_tb_pkg.sv
// Testbench package: expected-result types and the list scoreboard.
package pal_tb_pkg;

    import pal_pkg::*;

    localparam int LIST_DEPTH  = 64;

    // One expected or observed result beat
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic [6:0]  fill;
    } list_result_t;

    class list_scoreboard;
        logic [31:0]  cells [LIST_DEPTH];
        int unsigned  fill;
        int unsigned  errors;
        list_result_t expected_q [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Shift entries up and drop the word into the freed slot
        function void open_slot(input int unsigned idx, input logic [31:0] data);
            for (int unsigned i = fill; i > idx; i--)
                cells[i] = cells[i - 1];
            cells[idx] = data;
            fill++;
        endfunction

        // Take the word out and shift the tail down
        function logic [31:0] close_slot(input int unsigned idx);
            logic [31:0] word;
            word = cells[idx];
            for (int unsigned i = idx; i + 1 < fill; i++)
                cells[i] = cells[i + 1];
            fill--;
            return word;
        endfunction

        // Apply an accepted request to the shadow list and queue its result
        function void note_request(input logic [2:0] act, input logic [6:0] pos,
                                   input logic [31:0] data);
            list_result_t res;
            res.word   = '0;
            res.status = ST_OK;
            case (act)
                ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
                    if (fill >= LIST_DEPTH)
                        res.status = ST_FULL;
                    else if (act == ACT_INS_FRONT)
                        open_slot(0, data);
                    else if (act == ACT_INS_END)
                        open_slot(fill, data);
                    else if (pos > fill)
                        res.status = ST_RANGE;
                    else
                        open_slot(pos, data);
                end
                ACT_REM_FRONT, ACT_REM_END, ACT_REM_POS: begin
                    if (fill == 0)
                        res.status = ST_EMPTY;
                    else if (act == ACT_REM_FRONT)
                        res.word = close_slot(0);
                    else if (act == ACT_REM_END)
                        res.word = close_slot(fill - 1);
                    else if (pos >= fill)
                        res.status = ST_RANGE;
                    else
                        res.word = close_slot(pos);
                end
                default: ;
            endcase
            res.fill = 7'(fill);
            expected_q.push_back(res);
        endfunction

        // Compare one result beat against the oldest expectation
        function void check_result(input logic [31:0] word, input logic [1:0] status,
                                   input logic [6:0] cnt);
            list_result_t exp_res;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: word %h status %0d count %0d",
                         $time, word, status, cnt);
                return;
            end
            exp_res = expected_q.pop_front();
            if (word !== exp_res.word || status !== exp_res.status
                    || cnt !== exp_res.fill) begin
                errors++;
                $display({"%0t: mismatch: expected word %h status %0d count %0d,",
                          " actual word %h status %0d count %0d"},
                         $time, exp_res.word, exp_res.status, exp_res.fill,
                         word, status, cnt);
            end
        endfunction
    endclass

endpackage

### verif/positional_array_list_tb.sv
// Testbench for the positional array list: directed and random requests with scoreboard.
module positional_array_list_tb;

    import pal_pkg::*;
    import pal_tb_pkg::*;

    localparam int          RANDOM_ITEMS = 500;
    localparam int          HOLD_AT      = 350;
    localparam int          HOLD_CYCLES  = 120;
    localparam logic [2:0]  ACT_RSVD_A   = 3'd6;
    localparam logic [2:0]  ACT_RSVD_B   = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} stim_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    int   results_seen = 0;

    list_scoreboard sb;

    pal_req_if req_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every result beat at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            sb.check_result(rsp_ch.removed_data, rsp_ch.status, rsp_ch.entry_count);
            results_seen++;
        end
    end

    // Drive ready: random stalls, a stall-free stretch and one long hold-off
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else if (results_seen >= 150 && results_seen < 260)
                rsp_ch.ready = 1'b1;
            else
                rsp_ch.ready = ($urandom_range(0, 99) >= 37);
        end
    end

    // Offer one request beat, with optional random gaps, and note it on acceptance
    task automatic send_request(input logic [2:0] act, input logic [6:0] pos,
                                input logic [31:0] data, input bit allow_idle);
        @(negedge clk);
        while (allow_idle && $urandom_range(0, 99) < 37)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.action    = act;
        req_ch.position  = pos;
        req_ch.item_data = data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(act, pos, data);
    endtask

    // Hold off requests until every expected result has come back
    task automatic wait_for_drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Build one random request, biased by the stimulus mode
    function automatic void make_request(input stim_mode_t mode, input int unsigned fill,
                                         output logic [2:0] act, output logic [6:0] pos,
                                         output logic [31:0] data);
        int          roll;
        int          kind;
        bit          is_ins;
        int unsigned lim;
        int unsigned bad;
        roll = $urandom_range(0, 99);
        kind = $urandom_range(0, 2);
        case (mode)
            MODE_FILL:  is_ins = (roll < 85);
            MODE_DRAIN: is_ins = (roll >= 85);
            default:    is_ins = (roll < 55);
        endcase
        if (is_ins)
            act = (kind == 0) ? ACT_INS_FRONT : (kind == 1) ? ACT_INS_END : ACT_INS_POS;
        else
            act = (kind == 0) ? ACT_REM_FRONT : (kind == 1) ? ACT_REM_END : ACT_REM_POS;
        // Any code, reserved ones included, now and then in mixed traffic
        if (mode == MODE_MIXED && $urandom_range(0, 99) < 10)
            act = 3'($urandom_range(0, 7));

        // Mostly legal positions, some wild, some just past the end
        lim  = is_ins ? fill : ((fill == 0) ? 0 : fill - 1);
        bad  = is_ins ? fill + 1 : fill;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            pos = 7'($urandom_range(0, lim));
        else if (roll < 85)
            pos = 7'($urandom_range(0, 127));
        else
            pos = 7'((bad > 127) ? 127 : bad);

        roll = $urandom_range(0, 99);
        if (roll < 5)
            data = '0;
        else if (roll < 10)
            data = '1;
        else
            data = $urandom;
    endfunction

    // Empty-list, range and reserved-code cases, then each insert and remove kind
    task automatic run_directed();
        send_request(ACT_REM_FRONT, 7'd0,   32'h0,        1'b1);
        send_request(ACT_REM_END,   7'd0,   32'h0,        1'b1);
        send_request(ACT_REM_POS,   7'd0,   32'h0,        1'b1);
        send_request(ACT_REM_POS,   7'd127, 32'hFFFFFFFF, 1'b1);
        send_request(ACT_INS_POS,   7'd1,   32'h12345678, 1'b1);
        send_request(ACT_INS_POS,   7'd127, 32'hFFFFFFFF, 1'b1);
        send_request(ACT_RSVD_A,    7'd0,   32'hDEADBEEF, 1'b1);
        send_request(ACT_INS_FRONT, 7'd0,   32'hFFFFFFFF, 1'b1);
        send_request(ACT_INS_END,   7'd0,   32'h00000000, 1'b1);
        send_request(ACT_INS_POS,   7'd1,   32'hA5A5A5A5, 1'b1);
        send_request(ACT_INS_POS,   7'd3,   32'h5A5A5A5A, 1'b1);
        send_request(ACT_INS_POS,   7'd0,   32'h80000001, 1'b1);
        send_request(ACT_RSVD_B,    7'd127, 32'hFFFFFFFF, 1'b1);
        send_request(ACT_REM_POS,   7'd5,   32'h0,        1'b1);
        send_request(ACT_REM_POS,   7'd2,   32'h0,        1'b1);
        send_request(ACT_REM_FRONT, 7'd0,   32'h0,        1'b1);
        send_request(ACT_REM_END,   7'd0,   32'h0,        1'b1);
        send_request(ACT_REM_POS,   7'd0,   32'h0,        1'b1);
        send_request(ACT_REM_POS,   7'd0,   32'h0,        1'b1);
        send_request(ACT_REM_END,   7'd0,   32'h0,        1'b1);
    endtask

    // Bursts of fill, drain and mixed traffic
    task automatic run_random();
        int         sent;
        int         round;
        int         burst;
        int         extra;
        bit         done;
        stim_mode_t mode;
        logic [2:0]  act;
        logic [6:0]  pos;
        logic [31:0] data;
        sent  = 0;
        round = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (round == 0)
                mode = MODE_FILL;
            else if (round == 1)
                mode = MODE_DRAIN;
            else
                mode = stim_mode_t'($urandom_range(0, 2));
            round++;
            burst = $urandom_range(20, 60);
            extra = $urandom_range(2, 6);
            while (sent < RANDOM_ITEMS)
            begin
                // Run until the target is hit, then push a few more against it
                case (mode)
                    MODE_FILL:  done = (sb.fill == LIST_DEPTH);
                    MODE_DRAIN: done = (sb.fill == 0);
                    default:    done = (burst == 0);
                endcase
                if (done)
                begin
                    if (extra == 0)
                        break;
                    extra--;
                end
                else if (burst > 0)
                    burst--;
                make_request(mode, sb.fill, act, pos, data);
                send_request(act, pos, data, !(sent >= 200 && sent < 300));
                sent++;
                if (sent == 400)
                    wait_for_drain();
            end
        end
    endtask

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = '0;
        req_ch.position  = '0;
        req_ch.item_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        wait_for_drain();
        run_random();
        wait_for_drain();
        repeat (12) @(negedge clk);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/pal_pkg.sv
rtl/pal_req_if.sv
rtl/pal_rsp_if.sv
rtl/pal_cell.sv
rtl/pal_or_tree.sv
rtl/positional_array_list.sv
verif/pal_tb_pkg.sv
verif/positional_array_list_tb.sv
